@@ design/rlecc_pkg.sv @@
// Shared constants, types and codes of the run-length chunk compressor.
`default_nettype none
package rlecc_pkg;
	localparam int BLOCK_BYTES = 65536;
	localparam int TAKEN_W = $clog2(BLOCK_BYTES + 1);
	localparam int ADDR_W = 17;
	localparam int CHUNK_W = 7;
	localparam logic [CHUNK_W-1:0] MAX_CHUNK_RESET = 7'd127;
	localparam logic [CHUNK_W-1:0] MIN_CHUNK = 7'd2;
	localparam logic [7:0] RUN_FLAG = 8'h80;
	localparam int MAX_RES = 4;
	localparam int RES_IDX_W = $clog2(MAX_RES);
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		PH_EMPTY,
		PH_HELD,
		PH_RUN
	} phase_t;

	typedef struct packed {
		logic              write_enable;
		logic [ADDR_W-1:0] out_addr;
		logic [7:0]        out_byte;
		logic              chunk_done;
		logic [ADDR_W-1:0] compressed_length;
		logic              too_long;
	} result_t;

	typedef struct packed {
		logic [RES_CNT_W-1:0]      count;
		result_t [MAX_RES-1:0]     ent;
	} bundle_t;

	typedef struct packed {
		phase_t             phase;
		logic [7:0]         held;
		logic [CHUNK_W-1:0] run;
		logic [CHUNK_W-1:0] raw;
		logic [ADDR_W-1:0]  hdr;
		logic [ADDR_W-1:0]  wp;
		logic [TAKEN_W-1:0] taken;
	} enc_state_t;

	typedef struct packed {
		enc_state_t st;
		bundle_t    bnd;
	} work_t;
endpackage
`default_nettype wire

@@ design/rlecc_ifs.sv @@
// Valid/ready channel interfaces for input bytes and output writes.
`default_nettype none
interface rlecc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       block_end;

	modport source (output valid, output data_byte, output block_end, input ready);
	modport sink (input valid, input data_byte, input block_end, output ready);
endinterface

interface rlecc_out_if;
	logic        valid;
	logic        ready;
	logic        write_enable;
	logic [16:0] out_addr;
	logic [7:0]  out_byte;
	logic        chunk_done;
	logic [16:0] compressed_length;
	logic        too_long;

	modport source (output valid, output write_enable, output out_addr, output out_byte,
		output chunk_done, output compressed_length, output too_long, input ready);
	modport sink (input valid, input write_enable, input out_addr, input out_byte,
		input chunk_done, input compressed_length, input too_long, output ready);
endinterface
`default_nettype wire

@@ design/rlecc_front.sv @@
// Front end: accepts bytes, tracks chunk state and builds the writes of each byte.
`default_nettype none
module rlecc_front
	import rlecc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	rlecc_in_if.sink                feed,
	input  wire logic               cfg_we,
	input  wire logic [CHUNK_W-1:0] cfg_data,
	input  wire logic               q_full,
	output logic                    push,
	output bundle_t                 bundle
);
	logic [CHUNK_W-1:0] max_chunk_q;
	logic [CHUNK_W-1:0] lim;
	enc_state_t         st_q;
	work_t              w;
	logic               accept;
	logic               dropped;
	logic               same_byte;
	logic [ADDR_W-1:0]  len;
	logic [RES_IDX_W-1:0] last_idx;

	function automatic work_t put_word(work_t wi, logic [ADDR_W-1:0] addr, logic [7:0] data);
		work_t   r;
		result_t e;
		r = wi;
		e = '0;
		e.write_enable = 1'b1;
		e.out_addr = addr;
		e.out_byte = data;
		r.bnd.ent[r.bnd.count[RES_IDX_W-1:0]] = e;
		r.bnd.count = r.bnd.count + RES_CNT_W'(1);
		return r;
	endfunction

	function automatic work_t emit_run(work_t wi);
		work_t r;
		r = put_word(wi, wi.st.wp, RUN_FLAG | {1'b0, wi.st.run});
		r.st.wp = r.st.wp + ADDR_W'(1);
		r = put_word(r, r.st.wp, r.st.held);
		r.st.wp = r.st.wp + ADDR_W'(1);
		return r;
	endfunction

	function automatic work_t close_raw(work_t wi);
		work_t r;
		r = wi;
		if (r.st.raw != '0) begin
			r = put_word(r, r.st.hdr, {1'b0, r.st.raw});
			r.st.raw = '0;
		end
		return r;
	endfunction

	// Add the held byte to the raw chunk; open one by reserving its header slot.
	function automatic work_t append_raw(work_t wi, logic [CHUNK_W-1:0] lmt);
		work_t r;
		r = wi;
		if (r.st.raw == '0) begin
			r.st.hdr = r.st.wp;
			r.st.wp = r.st.wp + ADDR_W'(1);
		end
		r = put_word(r, r.st.wp, r.st.held);
		r.st.wp = r.st.wp + ADDR_W'(1);
		r.st.raw = r.st.raw + CHUNK_W'(1);
		if (r.st.raw >= lmt) begin
			r = close_raw(r);
		end
		return r;
	endfunction

	assign lim = (max_chunk_q < MIN_CHUNK) ? MIN_CHUNK : max_chunk_q;
	assign feed.ready = !q_full;
	assign accept = feed.valid && feed.ready;

	always_comb begin
		w.st = st_q;
		w.bnd = '0;
		len = '0;
		last_idx = '0;
		dropped = (st_q.taken >= TAKEN_W'(BLOCK_BYTES));
		same_byte = (feed.data_byte == st_q.held);
		if (!dropped) begin
			w.st.taken = st_q.taken + TAKEN_W'(1);
			case (st_q.phase)
				PH_EMPTY: begin
					w.st.held = feed.data_byte;
					w.st.run = CHUNK_W'(1);
					w.st.phase = PH_HELD;
				end
				PH_HELD: begin
					if (same_byte) begin
						w = close_raw(w);
						w.st.run = CHUNK_W'(2);
						w.st.phase = PH_RUN;
						if (w.st.run >= lim) begin
							w = emit_run(w);
							w.st.phase = PH_EMPTY;
							w.st.run = '0;
						end
					end else begin
						w = append_raw(w, lim);
						w.st.held = feed.data_byte;
						w.st.run = CHUNK_W'(1);
					end
				end
				PH_RUN: begin
					if (same_byte) begin
						w.st.run = w.st.run + CHUNK_W'(1);
						if (w.st.run >= lim) begin
							w = emit_run(w);
							w.st.phase = PH_EMPTY;
							w.st.run = '0;
						end
					end else begin
						w = emit_run(w);
						w.st.held = feed.data_byte;
						w.st.run = CHUNK_W'(1);
						w.st.phase = PH_HELD;
					end
				end
				default: begin
					w.st = st_q;
				end
			endcase
		end
		if (feed.block_end) begin
			case (w.st.phase)
				PH_HELD: begin
					w = append_raw(w, lim);
					w = close_raw(w);
				end
				PH_RUN: begin
					w = emit_run(w);
				end
				default: begin
				end
			endcase
			w = close_raw(w);
			len = w.st.wp;
			// Empty flush still closes the block with a no-write word.
			if (w.bnd.count == '0) begin
				w.bnd.count = RES_CNT_W'(1);
			end
			last_idx = RES_IDX_W'(w.bnd.count - RES_CNT_W'(1));
			w.bnd.ent[last_idx].chunk_done = 1'b1;
			w.bnd.ent[last_idx].compressed_length = len;
			w.st = '0;
		end
		if (dropped) begin
			if (w.bnd.count == '0) begin
				w.bnd.count = RES_CNT_W'(1);
			end
			for (int k = 0; k < MAX_RES; k++) begin
				w.bnd.ent[k].too_long = 1'b1;
			end
		end
	end

	assign bundle = w.bnd;
	assign push = accept && (w.bnd.count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			max_chunk_q <= MAX_CHUNK_RESET;
		end else begin
			if (accept) begin
				st_q <= w.st;
			end
			if (cfg_we) begin
				max_chunk_q <= cfg_data;
			end
		end
	end
endmodule
`default_nettype wire

@@ design/rlecc_queue.sv @@
// Short queue of write bundles between the front end and the write serializer.
`default_nettype none
module rlecc_queue
	import rlecc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  bundle_t      push_data,
	output logic         full,
	output logic         head_valid,
	output bundle_t      head,
	input  wire logic    pop
);
	bundle_t             slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     cnt_q;

	assign full = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W + 1)'(1);
			end
		end
	end
endmodule
`default_nettype wire

@@ design/rlecc_back.sv @@
// Back end: hands out bundle writes via an output register, one word per cycle unless stalled.
`default_nettype none
module rlecc_back
	import rlecc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      head_valid,
	input  bundle_t        head,
	output logic           pop,
	rlecc_out_if.source    writes
);
	logic [RES_IDX_W-1:0] idx_q;
	result_t              oreg_q;
	logic                 ovalid_q;
	logic                 load;
	logic                 last_word;

	assign load = head_valid && (!ovalid_q || writes.ready);
	assign last_word = (idx_q == RES_IDX_W'(head.count - RES_CNT_W'(1)));
	assign pop = load && last_word;

	always_ff @(posedge clk) begin
		if (load) begin
			oreg_q <= head.ent[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
				// Advance within the bundle; wrap to the first word once it drains.
				idx_q <= last_word ? '0 : idx_q + RES_IDX_W'(1);
			end else if (writes.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign writes.valid = ovalid_q;
	assign writes.write_enable = oreg_q.write_enable;
	assign writes.out_addr = oreg_q.out_addr;
	assign writes.out_byte = oreg_q.out_byte;
	assign writes.chunk_done = oreg_q.chunk_done;
	assign writes.compressed_length = oreg_q.compressed_length;
	assign writes.too_long = oreg_q.too_long;
endmodule
`default_nettype wire

@@ design/rle_chunk_compressor.sv @@
// Run-length chunk compressor top level: front end, bundle queue and write serializer.
// Path: a byte's writes are registered in a queue slot and then in the output register.
// Throughput: one byte per cycle while the four-bundle queue has room; a byte that makes
//   k writes holds the output for k words, so output word rate sets the sustained pace.
// Reset: arst_n clears chunk state, queue and output valid at once; max_chunk returns to 127.
`default_nettype none
module rle_chunk_compressor
	import rlecc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	rlecc_in_if.sink                feed,
	rlecc_out_if.source             writes,
	input  wire logic               cfg_we,
	input  wire logic [CHUNK_W-1:0] cfg_data
);
	logic    q_push;
	logic    q_full;
	logic    q_head_valid;
	logic    q_pop;
	bundle_t q_push_data;
	bundle_t q_head;

	rlecc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.feed     (feed),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.push     (q_push),
		.bundle   (q_push_data)
	);

	rlecc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_push_data),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop)
	);

	rlecc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.writes     (writes)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("bundle pushed into a full queue");

	a_bundle_size: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_push_data.count != '0) &&
			(q_push_data.count <= RES_CNT_W'(MAX_RES)))
		else $error("pushed bundle has an impossible word count");

	a_pop_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head_valid)
		else $error("queue popped while empty");

	a_idle_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(writes.valid && !writes.write_enable) |->
			(writes.out_addr == '0) && (writes.out_byte == '0))
		else $error("no-write word carries address or data");
endmodule
`default_nettype wire
